// ----- rtl/core/lrtt_pkg.sv -----
// Shared constants and types for the local rank template transform.
// Used by the channel interfaces, the configuration block, the rank cell and the top level.
package lrtt_pkg;

    localparam int CODE_W             = 16;
    localparam int OUT_W              = 16;
    localparam int CFG_W              = 5;
    localparam int DATA_W             = 32;
    localparam int ADDR_W             = 3;
    localparam int REG_IDX_W          = ADDR_W - 2;
    localparam int MAX_GROUP_DEF      = 16;
    localparam int MAX_BLOCK_BITS_DEF = 16;
    localparam int RESULT_CAP         = 16;

    localparam logic [CFG_W-1:0] BLOCK_BITS_RST = 5'd4;
    localparam logic [CFG_W-1:0] GRP_LEN_RST    = 5'd12;

    localparam logic [REG_IDX_W-1:0] REG_BLOCK_BITS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_GRP_LEN    = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] block_bits;
        logic [CFG_W-1:0] grp_len;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic rank_step;
        logic out_shift;
    } t_cell_ctrl;

endpackage

// ----- rtl/core/lrtt_in_if.sv -----
// Input channel carrying one template block and its key block per transfer.
// Depends on lrtt_pkg for the field widths.
interface lrtt_in_if import lrtt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_bits;
    logic [CODE_W-1:0] key_bits;
    logic              last_block;

    modport source (output valid, output code_bits, output key_bits, output last_block,
                    input ready);
    modport sink (input valid, input code_bits, input key_bits, input last_block,
                  output ready);
endinterface

// ----- rtl/core/lrtt_out_if.sv -----
// Output channel carrying one rank or raw block value per transfer.
// Depends on lrtt_pkg for the field widths.
interface lrtt_out_if import lrtt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] out_value;
    logic             is_rank;
    logic             last_of_run;

    modport source (output valid, output out_value, output is_rank, output last_of_run,
                    input ready);
    modport sink (input valid, input out_value, input is_rank, input last_of_run,
                  output ready);
endinterface

// ----- rtl/core/lrtt_cfg.sv -----
// APB-style configuration registers for block width and group size.
// Depends on lrtt_pkg.
module lrtt_cfg import lrtt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    logic [CFG_W-1:0]     r_block_bits;
    logic [CFG_W-1:0]     r_grp_len;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bits <= BLOCK_BITS_RST;
            r_grp_len    <= GRP_LEN_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_BLOCK_BITS: r_block_bits <= pwdata[CFG_W-1:0];
                REG_GRP_LEN:    r_grp_len    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_BLOCK_BITS: prdata = DATA_W'(r_block_bits);
            REG_GRP_LEN:    prdata = DATA_W'(r_grp_len);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.block_bits = r_block_bits;
    assign o_cfg.grp_len    = r_grp_len;
endmodule

// ----- rtl/core/lrtt_cell.sv -----
// One cell of the ranking chain: holds a block value, a circulating probe and a rank count.
// Depends on lrtt_pkg for the cell control struct.
module lrtt_cell import lrtt_pkg::*; #(
    parameter int VW = MAX_BLOCK_BITS_DEF,
    parameter int IW = 4
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [IW-1:0] i_idx,
    input  logic [VW-1:0] i_load_val,
    input  logic [VW-1:0] i_nb_trv_val,
    input  logic [IW-1:0] i_nb_trv_idx,
    input  logic [VW-1:0] i_nb_val,
    input  logic [IW-1:0] i_nb_rank,
    output logic [VW-1:0] o_trv_val,
    output logic [IW-1:0] o_trv_idx,
    output logic [VW-1:0] o_val,
    output logic [IW-1:0] o_rank
);
    logic [VW-1:0] r_val;
    logic [VW-1:0] r_trv_val;
    logic [IW-1:0] r_trv_idx;
    logic [IW-1:0] r_rank;
    logic          w_hit;

    // The probe counts against this cell if it is smaller, or equal and earlier.
    assign w_hit = (r_trv_val < r_val) || ((r_trv_val == r_val) && (r_trv_idx < i_idx));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_val     <= i_load_val;
            r_trv_val <= i_load_val;
            r_trv_idx <= i_idx;
            r_rank    <= '0;
        end else if (i_ctrl.rank_step) begin
            r_rank    <= r_rank + IW'(w_hit);
            r_trv_val <= i_nb_trv_val;
            r_trv_idx <= i_nb_trv_idx;
        end else if (i_ctrl.out_shift) begin
            r_val  <= i_nb_val;
            r_rank <= i_nb_rank;
        end
    end

    assign o_trv_val = r_trv_val;
    assign o_trv_idx = r_trv_idx;
    assign o_val     = r_val;
    assign o_rank    = r_rank;
endmodule

// ----- rtl/core/local_rank_template_transform_core.sv -----
// Top level of the local rank template transform: config port, rank cell chain and control.
// Depends on lrtt_pkg, lrtt_in_if, lrtt_out_if, lrtt_cfg and lrtt_cell.
//
//  Channel   Direction  Handshake          Payload
//  i_in      in         valid / ready      code_bits, key_bits, last_block
//  o_out     out        valid / ready      out_value, is_rank, last_of_run
//  APB       in / out   psel, penable      paddr, pwdata, prdata
//
// An item that closes no group is stored in the next free cell; one that completes a group of G
// values starts a ranking pass while the probes circle the ring of cells, then the G results
// follow, one per transfer at the output register, as do the N values of a trailing raw group.
// Input is held off during ranking and result delivery; a stalled output holds the chain.
// Reset is synchronous and sets block_bits to 4 and the group length to 12; there is no
// clearing pass.
module local_rank_template_transform_core import lrtt_pkg::*; #(
    parameter int MAX_GROUP      = MAX_GROUP_DEF,
    parameter int MAX_BLOCK_BITS = MAX_BLOCK_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lrtt_in_if.sink           i_in,
    lrtt_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    localparam int VW   = (MAX_BLOCK_BITS < CODE_W) ? MAX_BLOCK_BITS : CODE_W;
    localparam int IW   = $clog2(MAX_GROUP);
    localparam int CW   = $clog2(MAX_GROUP + 1);
    localparam int GCAP = (MAX_GROUP < RESULT_CAP) ? MAX_GROUP : RESULT_CAP;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RANK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    t_cfg          w_cfg;
    logic [CW-1:0] w_gs;
    logic [VW-1:0] w_mask;
    logic [VW-1:0] w_blk;
    logic          w_acc;
    logic          w_emit;
    logic [CW-1:0] w_fill_inc;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_left, n_left;
    logic             r_is_rank, n_is_rank;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_value, n_out_value;
    logic             r_out_rank, n_out_rank;
    logic             r_out_last, n_out_last;

    logic [VW-1:0] w_trv_val [MAX_GROUP];
    logic [IW-1:0] w_trv_idx [MAX_GROUP];
    logic [VW-1:0] w_val     [MAX_GROUP];
    logic [IW-1:0] w_rank    [MAX_GROUP];

    lrtt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        if (w_cfg.grp_len == '0) begin
            w_gs = CW'(1);
        end else if (int'(w_cfg.grp_len) > GCAP) begin
            w_gs = CW'(GCAP);
        end else begin
            w_gs = CW'(w_cfg.grp_len);
        end
    end

    always_comb begin
        for (int k = 0; k < VW; k++) begin
            w_mask[k] = (k < int'(w_cfg.block_bits));
        end
    end

    assign w_blk      = (i_in.code_bits[VW-1:0] ^ i_in.key_bits[VW-1:0]) & w_mask;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && (r_state == S_IDLE);
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign w_fill_inc = (int'(r_fill) < MAX_GROUP) ? r_fill + CW'(1) : r_fill;

    for (genvar k = 0; k < MAX_GROUP; k++) begin : g_cell
        t_cell_ctrl    w_ctrl;
        logic [VW-1:0] w_nb_trv_val;
        logic [IW-1:0] w_nb_trv_idx;
        logic [VW-1:0] w_nb_val;
        logic [IW-1:0] w_nb_rank;

        assign w_ctrl.load      = w_acc && (r_fill == CW'(k));
        assign w_ctrl.rank_step = (r_state == S_RANK);
        assign w_ctrl.out_shift = w_emit;

        // The ring closes at the last cell of the active group.
        if (k == MAX_GROUP - 1) begin : g_tail
            assign w_nb_trv_val = w_trv_val[0];
            assign w_nb_trv_idx = w_trv_idx[0];
            assign w_nb_val     = '0;
            assign w_nb_rank    = '0;
        end else begin : g_body
            assign w_nb_trv_val = (CW'(k) + CW'(1) == w_gs) ? w_trv_val[0] : w_trv_val[k+1];
            assign w_nb_trv_idx = (CW'(k) + CW'(1) == w_gs) ? w_trv_idx[0] : w_trv_idx[k+1];
            assign w_nb_val     = w_val[k+1];
            assign w_nb_rank    = w_rank[k+1];
        end

        lrtt_cell #(
            .VW (VW),
            .IW (IW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_idx        (IW'(k)),
            .i_load_val   (w_blk),
            .i_nb_trv_val (w_nb_trv_val),
            .i_nb_trv_idx (w_nb_trv_idx),
            .i_nb_val     (w_nb_val),
            .i_nb_rank    (w_nb_rank),
            .o_trv_val    (w_trv_val[k]),
            .o_trv_idx    (w_trv_idx[k]),
            .o_val        (w_val[k]),
            .o_rank       (w_rank[k])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_is_rank   = r_is_rank;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_value = r_out_value;
        n_out_rank  = r_out_rank;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_fill_inc >= w_gs) begin
                        n_state   = S_RANK;
                        n_cnt     = w_gs;
                        n_left    = w_gs;
                        n_is_rank = 1'b1;
                        n_fill    = '0;
                    end else if (i_in.last_block) begin
                        n_state   = S_EMIT;
                        n_left    = w_fill_inc;
                        n_is_rank = 1'b0;
                        n_fill    = '0;
                    end else begin
                        n_fill = w_fill_inc;
                    end
                end
            end
            S_RANK: begin
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_is_rank ? OUT_W'(w_rank[0]) : OUT_W'(w_val[0]);
                    n_out_rank  = r_is_rank;
                    n_out_last  = (r_left == CW'(1));
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_is_rank   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_is_rank   <= n_is_rank;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_rank  <= n_out_rank;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_value   = r_out_value;
    assign o_out.is_rank     = r_out_rank;
    assign o_out.last_of_run = r_out_last;

`ifndef NO_ASSERTIONS
    a_fill_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (int'(r_fill) < GCAP))
        else $error("Buffered count reached the group limit while idle.");

    a_emit_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_EMIT) && ($past(r_state) == S_EMIT)) |-> (r_out_valid && r_out_last))
        else $error("Result delivery ended without a final transfer marked last.");

    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rank) |-> (int'(r_out_value) < GCAP))
        else $error("A rank result lies outside the group.");
`endif
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for local_rank_template_transform_core: it predicts every rank or raw
// value, reprograms block width and group size over APB between phases, and varies flow control.
// Depends on lrtt_pkg, lrtt_in_if, lrtt_out_if and the core RTL.
module testbench;
    import lrtt_pkg::*;

    localparam int SETTLE_CYCLES    = 40;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PHASES    = 8;
    localparam int BLOCKS_PER_PHASE = 20;

    localparam int GAP_PCT   [4] = '{0, 51, 0, 32};
    localparam int STALL_PCT [4] = '{0, 0, 51, 32};

    localparam int PHASE_BLOCK_BITS [RANDOM_PHASES] = '{16, 1, 5, 0, 31, 12, 8, 3};
    localparam int PHASE_GRP_LEN    [RANDOM_PHASES] = '{16, 1, 3, 7, 16, 31, 0, 5};

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [CODE_W-1:0] key_bits;
        logic              last_block;
    } t_block;

    typedef struct packed {
        logic [OUT_W-1:0] out_value;
        logic             is_rank;
        logic             last_of_run;
    } t_rank_result;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lrtt_in_if  in_ch ();
    lrtt_out_if out_ch ();

    t_block       pending_blocks[$];
    t_rank_result expected_values[$];

    logic [CFG_W-1:0] model_block_bits = BLOCK_BITS_RST;
    logic [CFG_W-1:0] model_grp_len    = GRP_LEN_RST;
    logic [OUT_W-1:0] group_store[MAX_GROUP_DEF];
    int               group_fill = 0;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    local_rank_template_transform_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void rank_block(t_block blk);
        int               gsize;
        int               width;
        int               rank;
        logic [OUT_W-1:0] value;
        t_rank_result     res;
        gsize = model_grp_len;
        if (gsize < 1) gsize = 1;
        if (gsize > MAX_GROUP_DEF) gsize = MAX_GROUP_DEF;
        if (gsize > RESULT_CAP) gsize = RESULT_CAP;
        width = model_block_bits;
        if (width > MAX_BLOCK_BITS_DEF) width = MAX_BLOCK_BITS_DEF;
        if (width > OUT_W) width = OUT_W;
        value = (blk.code_bits ^ blk.key_bits) & OUT_W'((32'h1 << width) - 1);
        if (group_fill < MAX_GROUP_DEF) begin
            group_store[group_fill] = value;
            group_fill++;
        end
        if (group_fill >= gsize) begin
            for (int i = 0; i < gsize; i++) begin
                rank = 0;
                for (int j = 0; j < gsize; j++) begin
                    if (group_store[j] < group_store[i] ||
                        (group_store[j] == group_store[i] && j < i))
                        rank++;
                end
                res.out_value   = OUT_W'(rank);
                res.is_rank     = 1'b1;
                res.last_of_run = (i == gsize - 1);
                expected_values.push_back(res);
            end
            group_fill = 0;
        end else if (blk.last_block && group_fill > 0) begin
            for (int i = 0; i < group_fill; i++) begin
                res.out_value   = group_store[i];
                res.is_rank     = 1'b0;
                res.last_of_run = (i == group_fill - 1);
                expected_values.push_back(res);
            end
            group_fill = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_block next_blk;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                rank_block({in_ch.code_bits, in_ch.key_bits, in_ch.last_block});
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_blocks.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_blk = pending_blocks.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.code_bits  <= next_blk.code_bits;
                    in_ch.key_bits   <= next_blk.key_bits;
                    in_ch.last_block <= next_blk.last_block;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rank_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_values.size() == 0) begin
                    $display("%0t: unexpected transfer: value %h rank %b last %b", $time,
                             out_ch.out_value, out_ch.is_rank, out_ch.last_of_run);
                    error_count++;
                end else begin
                    want = expected_values.pop_front();
                    if (out_ch.out_value !== want.out_value || out_ch.is_rank !== want.is_rank
                        || out_ch.last_of_run !== want.last_of_run) begin
                        $display("%0t: mismatch: expected value %h rank %b last %b, got %h %b %b",
                                 $time, want.out_value, want.is_rank, want.last_of_run,
                                 out_ch.out_value, out_ch.is_rank, out_ch.last_of_run);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [REG_IDX_W-1:0] reg_idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({reg_idx, 2'b00});
        pwdata  <= (DATA_W'($urandom) & ~DATA_W'(5'h1F)) | DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_BLOCK_BITS) model_block_bits = value;
        else model_grp_len = value;
    endtask

    task automatic push_block(input logic [CODE_W-1:0] code, input logic [CODE_W-1:0] key,
                              input logic last);
        t_block blk;
        blk.code_bits  = code;
        blk.key_bits   = key;
        blk.last_block = last;
        pending_blocks.push_back(blk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_blocks.size() != 0 || in_ch.valid || expected_values.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.code_bits  = '0;
        in_ch.key_bits   = '0;
        in_ch.last_block = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings leave a two-value group open when the template ends.
        push_block(16'h0000, 16'hFFFF, 1'b0);
        push_block(16'h1234, 16'h1236, 1'b1);
        wait_drained();

        // Full width, a group closed by the last block, with tied values.
        cfg_write(REG_BLOCK_BITS, 5'd16);
        cfg_write(REG_GRP_LEN, 5'd4);
        push_block(16'hF0F0, 16'h0F0F, 1'b0);
        push_block(16'h0000, 16'h0000, 1'b0);
        push_block(16'hFFFF, 16'hFFFF, 1'b0);
        push_block(16'h8000, 16'h0001, 1'b1);
        wait_drained();

        cfg_write(REG_BLOCK_BITS, 5'd0);
        cfg_write(REG_GRP_LEN, 5'd0);
        push_block(16'hA5A5, 16'h1234, 1'b0);
        push_block(16'hFFFF, 16'h0000, 1'b1);
        wait_drained();

        cfg_write(REG_BLOCK_BITS, 5'd31);
        cfg_write(REG_GRP_LEN, 5'd31);
        push_block(16'hFFFF, 16'h0000, 1'b1);
        wait_drained();

        // Shrinking the group below the number of buffered values.
        cfg_write(REG_BLOCK_BITS, 5'd8);
        cfg_write(REG_GRP_LEN, 5'd16);
        for (int i = 0; i < 5; i++)
            push_block(CODE_W'($urandom), CODE_W'($urandom), 1'b0);
        wait_drained();
        cfg_write(REG_GRP_LEN, 5'd2);
        push_block(CODE_W'($urandom), CODE_W'($urandom), 1'b0);
        wait_drained();
        push_block(CODE_W'($urandom), CODE_W'($urandom), 1'b1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            cfg_write(REG_BLOCK_BITS, CFG_W'(PHASE_BLOCK_BITS[p]));
            cfg_write(REG_GRP_LEN, CFG_W'(PHASE_GRP_LEN[p]));
            send_gap_pct   = GAP_PCT[p % 4];
            recv_stall_pct = STALL_PCT[p % 4];
            for (int i = 0; i < BLOCKS_PER_PHASE; i++)
                push_block(CODE_W'($urandom), CODE_W'($urandom), $urandom_range(7) == 0);
            wait_drained();
        end

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
